// File: hdl/assert_macros.svh
// assertion helpers for the allocator
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define ASSERT_ALWAYS(label, clk, prop) \
	label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

// File: hdl/ffca_pkg.sv
package ffca_pkg;
	localparam int PageBytes = 1024;
	localparam int PageCount = 4;
	localparam int BlockHdr = 32;
	localparam int PageHdr = 24;
	localparam int TotalBytes = PageBytes * PageCount;
	localparam int AddrW = $clog2(TotalBytes);
	localparam int OffW = $clog2(PageBytes);
	localparam int PageW = (PageCount > 1) ? $clog2(PageCount) : 1;
	localparam int PcntW = $clog2(PageCount + 1);
	localparam int SizeW = 20;
	localparam int RecW = 21;
	localparam int FreshSize = PageBytes - PageHdr - BlockHdr;

	localparam logic [1:0] ST_DONE = 2'd0;
	localparam logic [1:0] ST_NO_SPACE = 2'd1;
	localparam logic [1:0] ST_BAD_RELEASE = 2'd2;
	localparam logic OP_ALLOC = 1'b0;
	localparam logic OP_RELEASE = 1'b1;

	typedef struct packed {
		logic opcode;
		logic [10:0] request_size;
		logic [11:0] release_address;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [11:0] payload_address;
	} out_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_APAGE,
		S_ARD,
		S_AEVAL,
		S_ASPLIT,
		S_RRD,
		S_REVAL,
		S_RNXT_RD,
		S_RNXT_EVAL,
		S_RPREV_RD,
		S_RPREV_EVAL,
		S_DONE
	} state_t;
endpackage

// File: hdl/ffca_ram.sv
module ffca_ram #(
	parameter int Width = 8,
	parameter int Depth = 16
) (
	input logic clk,
	input logic we,
	input logic [$clog2(Depth)-1:0] waddr,
	input logic [Width-1:0] wdata,
	input logic [$clog2(Depth)-1:0] raddr,
	output logic [Width-1:0] rdata
);
	logic [Width-1:0] mem [Depth];

	// one write and one registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// File: hdl/first_fit_coalescing_allocator.sv
// First-fit coalescing heap allocator over PageCount pages of PageBytes.
// Command word goes in on start when busy is low: opcode 0 allocates
// request_size payload bytes, opcode 1 releases the block whose payload
// starts at release_address. Exactly one result word comes back per
// command, shown for one cycle with done high; the receiver cannot stall.
// An allocate walks open pages newest first through one record memory
// port, one block record at a time (registered read then compare). It
// enters each page in turn, reads and compares each record visited,
// then writes the granted header and shows the result; a fresh page is
// opened when no open page fits. A release walks its page up to the
// target block the same way, then reads the successor and uses the kept
// predecessor, skipping the successor read when the target is the last
// block of its page. busy is high from the cycle after accept through
// the result cycle; the block then returns to idle, where the next
// command is taken, so one command is in flight at a time.
// Reset clears the open page count and the sequencer; the record memory
// needs no clearing, since walks only visit records that were written.
`include "assert_macros.svh"
module first_fit_coalescing_allocator import ffca_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	input in_word_t in_word,
	output logic busy,
	output logic done,
	output out_word_t out_word
);
	state_t state_q, state_d;
	logic [PcntW-1:0] pages_open_q;
	logic [PcntW-1:0] pi_q;
	logic [OffW:0] off_q;
	logic [OffW:0] prev_q;
	logic [OffW:0] nxt_q;
	logic [SizeW-1:0] prev_sz_q;
	logic prev_free_q;
	logic has_prev_q;
	logic op_q;
	logic [10:0] want_q;
	logic [AddrW-1:0] raddr_q;
	logic [SizeW-1:0] have_q;
	logic [SizeW-1:0] merged_q;
	logic [1:0] st_q;
	logic [AddrW-1:0] res_addr_q;

	logic we;
	logic [AddrW-1:0] waddr, mraddr;
	logic [RecW-1:0] wdata, rdata;

	ffca_ram #(.Width(RecW), .Depth(TotalBytes)) u_rec (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(mraddr), .rdata(rdata)
	);

	logic [PageW-1:0] cur_page;
	logic [PageW-1:0] rel_page;
	logic [OffW-1:0] rel_off;
	logic [SizeW-1:0] rsz;
	logic rused;
	logic [OffW+SizeW:0] nxt;
	logic [OffW+SizeW:0] off_hdr;
	logic fresh_ok;

	assign rel_page = raddr_q[AddrW-1 -: PageW];
	assign rel_off = raddr_q[OffW-1:0];
	assign cur_page = (op_q == OP_RELEASE) ? rel_page : PageW'(pi_q - 1'b1);
	assign rsz = rdata[SizeW-1:0];
	assign rused = rdata[RecW-1];
	assign off_hdr = (OffW+SizeW+1)'(off_q) + (OffW+SizeW+1)'(BlockHdr);
	assign nxt = off_hdr + (OffW+SizeW+1)'(rsz);
	// a fresh page is left and its free block holds the request
	assign fresh_ok = (pages_open_q < PcntW'(PageCount)) && (want_q <= 11'(FreshSize));

	function automatic logic [AddrW-1:0] rec_addr(logic [PageW-1:0] pg, logic [OffW:0] o);
		rec_addr = AddrW'({pg, o[OffW-1:0]});
	endfunction

	// sequencer next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) begin
					state_d = (in_word.opcode == OP_RELEASE) ? S_RRD : S_APAGE;
				end
			end
			S_APAGE: begin
				if (pi_q != '0) state_d = S_ARD;
				else if (fresh_ok) state_d = S_ASPLIT;
				else state_d = S_DONE;
			end
			S_ARD: state_d = S_AEVAL;
			S_AEVAL: begin
				if (!rused && rsz >= SizeW'(want_q)) state_d = S_ASPLIT;
				else if (nxt >= (OffW+SizeW+1)'(PageBytes)) state_d = S_APAGE;
				else state_d = S_ARD;
			end
			S_ASPLIT: state_d = S_DONE;
			S_RRD: begin
				if (PcntW'(rel_page) >= pages_open_q || off_q >= (OffW+1)'(PageBytes))
					state_d = S_DONE;
				else
					state_d = S_REVAL;
			end
			S_REVAL: begin
				if (off_hdr == (OffW+SizeW+1)'(rel_off)) begin
					if (!rused) state_d = S_DONE;
					else if (nxt < (OffW+SizeW+1)'(PageBytes)) state_d = S_RNXT_RD;
					else state_d = S_RPREV_RD;
				end else if (off_hdr > (OffW+SizeW+1)'(rel_off)) begin
					state_d = S_DONE;
				end else begin
					state_d = S_RRD;
				end
			end
			S_RNXT_RD: state_d = S_RNXT_EVAL;
			S_RNXT_EVAL: state_d = S_RPREV_RD;
			S_RPREV_RD: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// memory read address
	always_comb begin
		mraddr = rec_addr(cur_page, off_q);
		if (state_q == S_RNXT_RD) mraddr = rec_addr(cur_page, nxt_q);
	end

	// memory write and outputs
	always_comb begin
		we = 1'b0;
		waddr = rec_addr(cur_page, off_q);
		wdata = '0;
		case (state_q)
			S_ASPLIT: begin
				we = 1'b1;
				if (have_q - SizeW'(want_q) >= SizeW'(BlockHdr + 1)) begin
					wdata = {1'b1, SizeW'(want_q)};
				end else begin
					wdata = {1'b1, have_q};
				end
			end
			S_RPREV_RD: begin
				if (st_q == ST_DONE) begin
					we = 1'b1;
					if (has_prev_q && prev_free_q) begin
						waddr = rec_addr(cur_page, prev_q);
						wdata = {1'b0, prev_sz_q + SizeW'(BlockHdr) + merged_q};
					end else begin
						wdata = {1'b0, merged_q};
					end
				end
			end
			S_DONE: begin
				if (op_q == OP_ALLOC && st_q == ST_DONE
						&& have_q - SizeW'(want_q) >= SizeW'(BlockHdr + 1)) begin
					we = 1'b1;
					waddr = rec_addr(cur_page,
						(OffW+1)'(off_hdr + (OffW+SizeW+1)'(want_q)));
					wdata = {1'b0, have_q - SizeW'(want_q) - SizeW'(BlockHdr)};
				end
			end
			default: ;
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			pages_open_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == S_APAGE && pi_q == '0 && fresh_ok)
				pages_open_q <= pages_open_q + 1'b1;
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				op_q <= in_word.opcode;
				want_q <= (in_word.request_size == '0) ? 11'd1 : in_word.request_size;
				raddr_q <= AddrW'(in_word.release_address);
				pi_q <= pages_open_q;
				off_q <= (OffW+1)'(PageHdr);
				has_prev_q <= 1'b0;
				st_q <= (in_word.opcode == OP_RELEASE) ? ST_BAD_RELEASE : ST_NO_SPACE;
			end
			S_APAGE: begin
				off_q <= (OffW+1)'(PageHdr);
				if (pi_q == '0) begin
					// nothing fit: open the next page if it can hold the request
					if (fresh_ok) begin
						st_q <= ST_DONE;
						have_q <= SizeW'(FreshSize);
						pi_q <= pages_open_q + 1'b1;
					end
				end
			end
			S_AEVAL: begin
				if (!rused && rsz >= SizeW'(want_q)) begin
					have_q <= rsz;
					st_q <= ST_DONE;
				end else if (nxt >= (OffW+SizeW+1)'(PageBytes)) begin
					pi_q <= pi_q - 1'b1;
				end else begin
					off_q <= (OffW+1)'(nxt);
				end
			end
			S_ASPLIT: begin
				res_addr_q <= AddrW'({cur_page, off_hdr[OffW-1:0]});
			end
			S_REVAL: begin
				if (off_hdr == (OffW+SizeW+1)'(rel_off)) begin
					merged_q <= rsz;
					if (rused) st_q <= ST_DONE;
					nxt_q <= (OffW+1)'(nxt);
				end else begin
					prev_free_q <= !rused;
					prev_sz_q <= rsz;
					has_prev_q <= 1'b1;
					off_q <= (nxt >= (OffW+SizeW+1)'(PageBytes)) ?
						(OffW+1)'(PageBytes) : (OffW+1)'(nxt);
					prev_q <= off_q;
				end
			end
			S_RNXT_EVAL: begin
				if (!rused) merged_q <= merged_q + SizeW'(BlockHdr) + rsz;
			end
			default: ;
		endcase
	end

	assign busy = (state_q != S_IDLE);
	assign done = (state_q == S_DONE);
	assign out_word.status = st_q;
	assign out_word.payload_address =
		(st_q == ST_DONE && op_q == OP_ALLOC) ? 12'(res_addr_q) : 12'd0;

	`ASSERT_CLK(a_done_busy, clk, arst_n, done |-> busy)
	`ASSERT_CLK(a_done_once, clk, arst_n, done |=> !done)
	`ASSERT_CLK(a_pages_max, clk, arst_n, pages_open_q <= PcntW'(PageCount))
	`ASSERT_CLK(a_pages_grow, clk, arst_n,
		(pages_open_q != $past(pages_open_q)) |-> $past(state_q == S_APAGE))
endmodule
